/* design/wppc_pkg.sv */
`default_nettype none
package wppc_pkg;

    localparam int DEF_MAX_PARAMS = 32;
    localparam int DEF_MEM_DEPTH  = 256;

    localparam logic [7:0]  HDR_FF     = 8'hFF;
    localparam logic [7:0]  HDR_FD     = 8'hFD;
    localparam logic [7:0]  HDR_ZERO   = 8'h00;
    localparam logic [7:0]  INSTR_WR   = 8'h03;
    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [15:0] MIN_LEN    = 16'd5;
    localparam logic [15:0] LEN_OVHD   = 16'd3;
    localparam logic [4:0]  MOD_STEPS  = 5'd4;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_CRC_ERR = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR = 2'd2;
    localparam logic [1:0] KIND_NO_DATA = 2'd3;

    typedef struct packed {
        logic       crc_seed;
        logic       crc_feed;
        logic       len_lo_ld;
        logic       len_hi_ld;
        logic       param_wr;
        logic       crc_lo_ld;
        logic       mod_start;
        logic       mod_step;
        logic       rd_start;
        logic       out_ld;
        logic [1:0] out_kind;
    } t_cmd;

    typedef struct packed {
        logic is_ff;
        logic is_fd;
        logic is_zero;
        logic is_id;
        logic is_wr;
        logic len_bad;
        logic params_last;
        logic crc_ok;
        logic mod_done;
        logic no_data;
        logic emit_last;
        logic out_free;
    } t_status;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/write_packet_parser_crc16.sv */
`default_nettype none
// Write packet receiver: takes one byte per cycle while parsing a packet (header FF FF FD 00,
// id, length, instruction 03, parameters, CRC-16/8005), updating the CRC on the fly.
// The byte that ends the length field or the CRC field stalls while the output register
// still holds an untaken item. After a good CRC the start address is reduced modulo
// MEM_DEPTH by a constant reciprocal multiply, a multiply back, a subtract and one
// correcting subtract (no input taken), then each write item is fetched by a registered
// read of the parameter RAM and waits for a free output register.
module write_packet_parser_crc16 #(
    parameter int MAX_PARAMS = wppc_pkg::DEF_MAX_PARAMS,
    parameter int MEM_DEPTH  = wppc_pkg::DEF_MEM_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] address, [15:8] data
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data      // device_id
);
    import wppc_pkg::*;

    t_cmd    cmd;
    t_status st;

    wppc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    wppc_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .MEM_DEPTH  (MEM_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );
endmodule
`default_nettype wire

/* design/wppc_ram.sv */
`default_nettype none
module wppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

/* design/wppc_ctrl.sv */
`default_nettype none
module wppc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire wppc_pkg::t_status  i_st,
    output wppc_pkg::t_cmd          o_cmd
);
    import wppc_pkg::*;

    localparam logic [3:0] S_HUNT    = 4'd0;
    localparam logic [3:0] S_FF2     = 4'd1;
    localparam logic [3:0] S_FD      = 4'd2;
    localparam logic [3:0] S_ZERO    = 4'd3;
    localparam logic [3:0] S_ID      = 4'd4;
    localparam logic [3:0] S_LEN_LO  = 4'd5;
    localparam logic [3:0] S_LEN_HI  = 4'd6;
    localparam logic [3:0] S_INSTR   = 4'd7;
    localparam logic [3:0] S_PARAM   = 4'd8;
    localparam logic [3:0] S_CRC_LO  = 4'd9;
    localparam logic [3:0] S_CRC_HI  = 4'd10;
    localparam logic [3:0] S_MOD     = 4'd11;
    localparam logic [3:0] S_RD      = 4'd12;
    localparam logic [3:0] S_LD      = 4'd13;
    localparam logic [3:0] S_NODATA  = 4'd14;

    logic [3:0] r_state, n_state;
    logic       fire;

    always_comb begin
        unique case (r_state) inside
            S_LEN_HI, S_CRC_HI:           o_ready = i_st.out_free;
            S_MOD, S_RD, S_LD, S_NODATA:  o_ready = 1'b0;
            default:                      o_ready = 1'b1;
        endcase
    end

    assign fire = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_FF2: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    n_state = i_st.is_ff ? S_FD : S_HUNT;
                end
            end
            S_FD: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    n_state = i_st.is_fd ? S_ZERO : S_HUNT;
                end
            end
            S_ZERO: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    n_state = i_st.is_zero ? S_ID : S_HUNT;
                end
            end
            S_ID: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    n_state = i_st.is_id ? S_LEN_LO : S_HUNT;
                end
            end
            S_LEN_LO: begin
                if (fire) begin
                    o_cmd.crc_feed  = 1'b1;
                    o_cmd.len_lo_ld = 1'b1;
                    n_state = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    if (i_st.len_bad) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = KIND_LEN_ERR;
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.len_hi_ld = 1'b1;
                        n_state = S_INSTR;
                    end
                end
            end
            S_INSTR: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    n_state = i_st.is_wr ? S_PARAM : S_HUNT;
                end
            end
            S_PARAM: begin
                if (fire) begin
                    o_cmd.crc_feed = 1'b1;
                    o_cmd.param_wr = 1'b1;
                    if (i_st.params_last) begin
                        n_state = S_CRC_LO;
                    end
                end
            end
            S_CRC_LO: begin
                if (fire) begin
                    o_cmd.crc_lo_ld = 1'b1;
                    n_state = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (fire) begin
                    if (i_st.crc_ok) begin
                        o_cmd.mod_start = 1'b1;
                        n_state = S_MOD;
                    end else begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = KIND_CRC_ERR;
                        n_state = S_HUNT;
                    end
                end
            end
            S_MOD: begin
                if (i_st.mod_done) begin
                    if (i_st.no_data) begin
                        n_state = S_NODATA;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (i_st.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = KIND_WRITE;
                    n_state = i_st.emit_last ? S_HUNT : S_RD;
                end
            end
            S_NODATA: begin
                if (i_st.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = KIND_NO_DATA;
                    n_state = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
                if (fire && i_st.is_ff) begin
                    o_cmd.crc_seed = 1'b1;
                    n_state = S_FF2;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* design/wppc_dp.sv */
`default_nettype none
module wppc_dp #(
    parameter int MAX_PARAMS = wppc_pkg::DEF_MAX_PARAMS,
    parameter int MEM_DEPTH  = wppc_pkg::DEF_MEM_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_byte,
    input  wire wppc_pkg::t_cmd     i_cmd,
    output wppc_pkg::t_status       o_st,
    input  wire logic               i_cfg_valid,
    input  wire logic [7:0]         i_cfg_data,
    output logic                    o_cfg_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [15:0]             o_out_data,
    output logic [1:0]              o_out_kind,
    output logic                    o_out_last
);
    import wppc_pkg::*;

    localparam int PW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam logic [15:0] MaxLen   = 16'(MAX_PARAMS + 3);
    localparam logic [15:0] LastAddr = 16'(MEM_DEPTH - 1);
    localparam logic [31:0] Depth32  = 32'(MEM_DEPTH);
    localparam logic [31:0] Recip    = 32'((64'd1 << 32) / 64'(MEM_DEPTH));
    localparam logic [4:0]  StepMul  = 5'd0;
    localparam logic [4:0]  StepBack = 5'd1;
    localparam logic [4:0]  StepSub  = 5'd2;
    localparam logic [4:0]  StepFix  = 5'd3;

    logic [7:0]    r_dev_id;
    logic [15:0]   r_crc;
    logic [7:0]    r_len_lo;
    logic [7:0]    r_crc_lo;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_pidx;
    logic [PW-1:0] r_rd_idx;
    logic [15:0]   r_start;
    logic [15:0]   r_rem;
    logic [47:0]   r_prod;
    logic [15:0]   r_qd;
    logic [4:0]    r_mcnt;
    logic [15:0]   r_addr;
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [7:0]    r_out_addr;
    logic [7:0]    r_out_data;
    logic          r_out_last;
    logic [7:0]    ram_rdata;
    logic [15:0]   len_full;

    assign o_cfg_ready = 1'b1;
    assign len_full    = {i_byte, r_len_lo};

    assign o_st.is_ff       = (i_byte == HDR_FF);
    assign o_st.is_fd       = (i_byte == HDR_FD);
    assign o_st.is_zero     = (i_byte == HDR_ZERO);
    assign o_st.is_id       = (i_byte == r_dev_id);
    assign o_st.is_wr       = (i_byte == INSTR_WR);
    assign o_st.len_bad     = (len_full < MIN_LEN) || (len_full > MaxLen);
    assign o_st.params_last = (r_left == CW'(1));
    assign o_st.crc_ok      = ({i_byte, r_crc_lo} == r_crc);
    assign o_st.mod_done    = (r_mcnt == MOD_STEPS);
    assign o_st.no_data     = (r_pidx == CW'(2));
    assign o_st.emit_last   = ((CW'(r_rd_idx) + CW'(1)) == r_pidx);
    assign o_st.out_free    = !r_out_valid || i_out_ready;

    wppc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARAMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.param_wr),
        .i_wr_addr (r_pidx[PW-1:0]),
        .i_wr_data (i_byte),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id    <= 8'd1;
            r_crc       <= '0;
            r_len_lo    <= '0;
            r_crc_lo    <= '0;
            r_left      <= '0;
            r_pidx      <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dev_id <= i_cfg_data;
            end
            if (i_cmd.crc_seed || i_cmd.crc_feed) begin
                r_crc <= crc16_feed(i_cmd.crc_seed ? 16'h0000 : r_crc, i_byte);
            end
            if (i_cmd.len_lo_ld) begin
                r_len_lo <= i_byte;
            end
            if (i_cmd.len_hi_ld) begin
                r_left <= CW'(len_full - LEN_OVHD);
                r_pidx <= '0;
            end else if (i_cmd.param_wr) begin
                r_left <= r_left - CW'(1);
                r_pidx <= r_pidx + CW'(1);
            end
            if (i_cmd.crc_lo_ld) begin
                r_crc_lo <= i_byte;
            end
            if (i_cmd.mod_start) begin
                r_mcnt <= '0;
            end else if (i_cmd.mod_step) begin
                r_mcnt <= r_mcnt + 5'd1;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.param_wr) begin
            if (r_pidx == CW'(0)) begin
                r_start[7:0] <= i_byte;
            end
            if (r_pidx == CW'(1)) begin
                r_start[15:8] <= i_byte;
            end
        end
        // start address modulo the memory depth: reciprocal quotient estimate,
        // multiply back, subtract, then one correcting subtract
        if (i_cmd.mod_start) begin
            r_rem <= r_start;
        end else if (i_cmd.mod_step) begin
            case (r_mcnt)
                StepMul: begin
                    r_prod <= 48'(r_rem) * 48'(Recip);
                end
                StepBack: begin
                    r_qd <= 16'(32'(r_prod[47:32]) * Depth32);
                end
                StepSub: begin
                    r_rem <= r_rem - r_qd;
                end
                StepFix: begin
                    if ({16'h0000, r_rem} >= Depth32) begin
                        r_rem <= r_rem - Depth32[15:0];
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.rd_start) begin
            r_rd_idx <= PW'(2);
            r_addr   <= r_rem;
        end else if (i_cmd.out_ld && i_cmd.out_kind == KIND_WRITE) begin
            r_rd_idx <= r_rd_idx + PW'(1);
            r_addr   <= (r_addr == LastAddr) ? 16'h0000 : r_addr + 16'd1;
        end
        if (i_cmd.out_ld) begin
            r_out_kind <= i_cmd.out_kind;
            case (i_cmd.out_kind)
                KIND_WRITE: begin
                    r_out_addr <= r_addr[7:0];
                    r_out_data <= ram_rdata;
                    r_out_last <= o_st.emit_last;
                end
                KIND_NO_DATA: begin
                    r_out_addr <= r_rem[7:0];
                    r_out_data <= '0;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_addr <= '0;
                    r_out_data <= '0;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_data, r_out_addr};
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> o_st.out_free)
        else $error("result loaded over a pending item");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_st.mod_done |-> ({16'h0000, r_rem} < Depth32))
        else $error("start address not reduced below depth");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_ld && i_cmd.out_kind == KIND_WRITE) |-> (r_addr <= LastAddr))
        else $error("write address beyond memory depth");
endmodule
`default_nettype wire
